>>> rtl/core/shta_pkg.sv
// Package for the simhash token accumulator.
// Holds the fixed widths, the token request struct and the one-at-a-time hash functions.
// No dependencies.
package shta_pkg;

  localparam int HASH_BITS = 32;
  localparam int BYTE_BITS = 8;
  localparam int FP_BITS   = 64;

  // Closed token request from the hash stage to the tally bank
  typedef struct packed {
    logic                 vld;
    logic                 doc;
    logic [HASH_BITS-1:0] mix;
  } tok_t;

  // One mixing round of the one-at-a-time hash
  function automatic logic [HASH_BITS-1:0] oaat_mix(
    input logic [HASH_BITS-1:0] h_in,
    input logic [BYTE_BITS-1:0] b
  );
    logic [HASH_BITS-1:0] h;
    h = h_in + {{(HASH_BITS-BYTE_BITS){1'b0}}, b};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  // Final avalanche of the one-at-a-time hash
  function automatic logic [HASH_BITS-1:0] oaat_final(
    input logic [HASH_BITS-1:0] h_in
  );
    logic [HASH_BITS-1:0] h;
    h = h_in + (h_in << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

endpackage

>>> rtl/core/simhash_token_accumulator.sv
// Simhash token accumulator top level: hash stage feeding the tally bank.
// Depends on shta_pkg, shta_hash_stage and shta_tally_bank.
//
// Accepts one token byte per cycle on the in_ stream unless held back (tlast closes a token,
// tuser closes the document) and returns one 64-bit fingerprint per document on the out_
// stream. Sustained rate is one byte per clock when not held back; the running one-at-a-time
// hash register is the only loop between bytes. A fingerprint passes through the input
// register, the token register, then the tally update and result register. Only a document
// end waiting on a full result register holds the input back. Bit i of the fingerprint is
// set where tally i is positive; bits 63..32 are always zero. Each tally is a signed
// TALLY_BITS counter that holds at its limits, and all state clears after each document.
module simhash_token_accumulator #(
  parameter int TALLY_BITS = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [shta_pkg::BYTE_BITS-1:0] in_tdata,   // [7:0] token_byte
  input  logic                           in_tlast,   // token_end
  input  logic                           in_tuser,   // doc_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [shta_pkg::FP_BITS-1:0]   out_tdata   // [63:0] fingerprint
);

  shta_pkg::tok_t tok;
  logic           tok_ready;

  // Hash each token byte by byte
  shta_hash_stage u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .tok       (tok),
    .tok_ready (tok_ready)
  );

  // Vote closed tokens into the tallies and emit fingerprints
  shta_tally_bank #(
    .TALLY_BITS (TALLY_BITS)
  ) u_tally (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok        (tok),
    .tok_ready  (tok_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/core/shta_hash_stage.sv
// Hash stage: input register, running token hash, closed-token register.
// Depends on shta_pkg (tok_t, oaat_mix).
module shta_hash_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [shta_pkg::BYTE_BITS-1:0] in_tdata,   // [7:0] token_byte
  input  logic                           in_tlast,   // token_end
  input  logic                           in_tuser,   // doc_end
  output shta_pkg::tok_t                 tok,
  input  logic                           tok_ready
);

  logic                           in_vld_r, in_vld_nxt;
  logic [shta_pkg::BYTE_BITS-1:0] in_byte_r;
  logic                           in_tok_r;
  logic                           in_doc_r;
  logic [shta_pkg::HASH_BITS-1:0] acc_r, acc_nxt;
  logic                           tk_vld_r, tk_vld_nxt;
  logic                           tk_doc_r;
  logic [shta_pkg::HASH_BITS-1:0] tk_mix_r;
  logic [shta_pkg::HASH_BITS-1:0] mixed;
  logic                           in_ends;
  logic                           in_go;
  logic                           tk_load;

  // Advance the held byte when it does not close a token or the token slot frees
  assign in_ends   = in_tok_r | in_doc_r;
  assign in_go     = in_vld_r & (~in_ends | tok_ready);
  assign in_tready = ~in_vld_r | in_go;
  assign tk_load   = in_go & in_ends;
  assign mixed     = shta_pkg::oaat_mix(acc_r, in_byte_r);

  // Next values of control and running hash
  always_comb begin
    in_vld_nxt = (in_vld_r & ~in_go) | in_tvalid;
    if (!in_tready) begin
      in_vld_nxt = in_vld_r;
    end
    acc_nxt = acc_r;
    if (in_go) begin
      acc_nxt = in_ends ? '0 : mixed;
    end
    tk_vld_nxt = (tk_vld_r & ~tok_ready) | tk_load;
  end

  // Control state and running hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      tk_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      tk_vld_r <= tk_vld_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_tok_r  <= in_tlast;
      in_doc_r  <= in_tuser;
    end
    if (tk_load) begin
      tk_mix_r <= mixed;
      tk_doc_r <= in_doc_r;
    end
  end

  assign tok.vld = tk_vld_r;
  assign tok.doc = tk_doc_r;
  assign tok.mix = tk_mix_r;

`ifndef SYNTHESIS
  // A closed token restarts the running hash
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    tk_load |=> (acc_r == '0))
    else $error("running hash not cleared after token end");

  // A waiting token request is neither lost nor overwritten
  a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tk_vld_r && !tok_ready) |=> (tk_vld_r && $stable(tk_mix_r) && $stable(tk_doc_r)))
    else $error("token request changed while waiting");
`endif

endmodule

>>> rtl/core/shta_tally_bank.sv
// Tally bank: final hash avalanche, saturating per-bit tallies and fingerprint register.
// Depends on shta_pkg (tok_t, oaat_final, widths).
module shta_tally_bank #(
  parameter int TALLY_BITS = 17
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  shta_pkg::tok_t               tok,
  output logic                         tok_ready,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [shta_pkg::FP_BITS-1:0] out_tdata   // [63:0] fingerprint
);

  localparam logic [TALLY_BITS-1:0] TMAX = {1'b0, {(TALLY_BITS-1){1'b1}}};
  localparam logic [TALLY_BITS-1:0] TMIN = {1'b1, {(TALLY_BITS-1){1'b0}}};

  logic [TALLY_BITS-1:0]          tally_r   [shta_pkg::HASH_BITS];
  logic [TALLY_BITS-1:0]          tally_nxt [shta_pkg::HASH_BITS];
  logic [TALLY_BITS-1:0]          tally_upd [shta_pkg::HASH_BITS];
  logic [shta_pkg::HASH_BITS-1:0] h;
  logic [shta_pkg::HASH_BITS-1:0] fp_bits;
  logic                           tk_go;
  logic                           out_vld_r, out_vld_nxt;
  logic [shta_pkg::FP_BITS-1:0]   out_fp_r;
  logic                           any_nz;

  // Take a token unless it ends a document and the result slot stays full
  assign tk_go       = tok.vld & (~tok.doc | ~out_vld_r | out_tready);
  assign tok_ready   = ~tok.vld | tk_go;
  assign out_vld_nxt = (out_vld_r & ~out_tready) | (tk_go & tok.doc);
  assign h           = shta_pkg::oaat_final(tok.mix);

  // Vote each lane up or down, holding at the signed limits
  always_comb begin
    any_nz = 1'b0;
    for (int i = 0; i < shta_pkg::HASH_BITS; i++) begin
      if (h[i]) begin
        tally_upd[i] = (tally_r[i] == TMAX) ? tally_r[i] : tally_r[i] + TALLY_BITS'(1);
      end else begin
        tally_upd[i] = (tally_r[i] == TMIN) ? tally_r[i] : tally_r[i] - TALLY_BITS'(1);
      end
      fp_bits[i] = ~tally_upd[i][TALLY_BITS-1] & (tally_upd[i] != '0);
      if (!tk_go) begin
        tally_nxt[i] = tally_r[i];
      end else if (tok.doc) begin
        tally_nxt[i] = '0;
      end else begin
        tally_nxt[i] = tally_upd[i];
      end
      any_nz = any_nz | (tally_r[i] != '0);
    end
  end

  // Tallies and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      for (int i = 0; i < shta_pkg::HASH_BITS; i++) begin
        tally_r[i] <= '0;
      end
    end else begin
      out_vld_r <= out_vld_nxt;
      for (int i = 0; i < shta_pkg::HASH_BITS; i++) begin
        tally_r[i] <= tally_nxt[i];
      end
    end
  end

  // Fingerprint register; upper half stays zero
  always_ff @(posedge clk) begin
    if (tk_go && tok.doc) begin
      out_fp_r <= {{(shta_pkg::FP_BITS-shta_pkg::HASH_BITS){1'b0}}, fp_bits};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_fp_r;

`ifndef SYNTHESIS
  // Document end leaves every tally cleared
  a_doc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (tk_go && tok.doc) |=> !any_nz)
    else $error("tallies not cleared after document end");

  // A result appears only for a document-ending token
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(tk_go && tok.doc))
    else $error("result without document end");

  // Upper fingerprint half is always zero
  a_fp_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_fp_r[shta_pkg::FP_BITS-1:shta_pkg::HASH_BITS] == '0))
    else $error("upper fingerprint bits set");
`endif

endmodule
